// ===== hw/rtl/smpg_pkg.sv =====
// Types and constants shared by the stepper move pulse generator.
`timescale 1ns / 1ps

package smpg_pkg;

  // Input beat codes
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_HOME = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_POSITION      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_HALF_PERIOD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_HALF_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_STEP         = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_DISTANCE     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSES_PER_UNIT   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_TICKS    = 3'd6;
  localparam int unsigned CFG_DATA_BITS = 20;

  // Register reset values
  localparam logic signed [15:0] RST_MAX_POSITION      = 16'sd1000;
  localparam logic        [15:0] RST_START_HALF_PERIOD = 16'd500;
  localparam logic        [15:0] RST_SLOW_HALF_PERIOD  = 16'd600;
  localparam logic        [7:0]  RST_RAMP_STEP         = 8'd2;
  localparam logic        [16:0] RST_RAMP_DISTANCE     = 17'd1500;
  localparam logic        [7:0]  RST_PULSES_PER_UNIT   = 8'd10;
  localparam logic        [19:0] RST_DEBOUNCE_TICKS    = 20'd50000;

  localparam logic [16:0] UNITS_MAX  = 17'h1FFFF;
  localparam logic [15:0] PERIOD_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2,
    MODE_WAIT = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] target;
    logic               home_switch_pressed;
  } in_beat_t;

  typedef struct packed {
    logic               step_level;
    logic               direction;
    logic               busy_res;
    logic               done_res;
    logic               rejected;
    logic signed [15:0] position;
  } out_beat_t;

endpackage

// ===== hw/rtl/stepper_move_pulse_generator_unit.sv =====
// Step/direction pulse generator for one stepper axis, with ramp and homing.
// The result beat for an input beat is registered and presented in the cycle after acceptance.
// Throughput: one input beat per cycle while the result is not stalled; the axis state update is a single
//   combinational pass from the state registers to the result register.
// A stalled result holds the input off; a new beat is taken in the cycle the result leaves.
// Reset (rst_ni low, asynchronous): configuration to defaults, axis idle at position 0.
`timescale 1ns / 1ps

module stepper_move_pulse_generator_unit
  import smpg_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input beats: ticks and commands
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_beat_t                 in_data_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_beat_t                out_data_o,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // Widths for sign extension and the distance calculation
  localparam int unsigned EXT_BITS  = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam int unsigned DIST_BITS = POSITION_BITS + 1;
  localparam int unsigned SAT_BITS  = (DIST_BITS > 17) ? DIST_BITS : 17;

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready, written at any time
  // ---------------------------------------------------------------------------
  logic signed [15:0] max_pos_q;
  logic [15:0]        start_hp_q;
  logic [15:0]        slow_hp_q;
  logic [7:0]         ramp_step_q;
  logic [16:0]        ramp_dist_q;
  logic [7:0]         ppu_q;
  logic [19:0]        debounce_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pos_q   <= RST_MAX_POSITION;
      start_hp_q  <= RST_START_HALF_PERIOD;
      slow_hp_q   <= RST_SLOW_HALF_PERIOD;
      ramp_step_q <= RST_RAMP_STEP;
      ramp_dist_q <= RST_RAMP_DISTANCE;
      ppu_q       <= RST_PULSES_PER_UNIT;
      debounce_q  <= RST_DEBOUNCE_TICKS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAX_POSITION:      max_pos_q   <= $signed(cfg_data_i[15:0]);
        REG_START_HALF_PERIOD: start_hp_q  <= cfg_data_i[15:0];
        REG_SLOW_HALF_PERIOD:  slow_hp_q   <= cfg_data_i[15:0];
        REG_RAMP_STEP:         ramp_step_q <= cfg_data_i[7:0];
        REG_RAMP_DISTANCE:     ramp_dist_q <= cfg_data_i[16:0];
        REG_PULSES_PER_UNIT:   ppu_q       <= cfg_data_i[7:0];
        REG_DEBOUNCE_TICKS:    debounce_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Axis state
  // ---------------------------------------------------------------------------
  mode_e                           mode_q, mode_d;
  logic signed [POSITION_BITS-1:0] pos_q, pos_d;
  logic signed [POSITION_BITS-1:0] tgt_q, tgt_d;
  logic [16:0]                     rem_q, rem_d;
  logic [7:0]                      piu_q, piu_d;
  logic [15:0]                     hp_q, hp_d;
  logic [19:0]                     phase_q, phase_d;
  logic                            high_q, high_d;
  logic                            dir_q, dir_d;

  logic      out_valid_q;
  out_beat_t out_q, res_d;
  logic      done_d, rej_d;

  // Accept whenever the result slot is free or draining this cycle
  logic in_fire;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic is_tick, is_move, is_home, is_cmd, busy, pressed;
  assign is_tick = (in_data_i.kind == KIND_TICK);
  assign is_move = (in_data_i.kind == KIND_MOVE);
  assign is_home = (in_data_i.kind == KIND_HOME);
  assign is_cmd  = is_move || is_home;
  assign busy    = (mode_q != MODE_IDLE);
  assign pressed = in_data_i.home_switch_pressed;

  // Move set-up: clamp above, wrap to position width, distance with saturation
  logic signed [15:0]              tgt_clamp;
  logic signed [EXT_BITS-1:0]      tgt_ext;
  logic signed [POSITION_BITS-1:0] tgt_w;
  logic signed [DIST_BITS-1:0]     tgt_x, pos_x, dist_s;
  logic [SAT_BITS-1:0]             dist_w;
  logic [16:0]                     units;
  logic                            move_dir, move_null;

  assign tgt_clamp = ($signed(in_data_i.target) > max_pos_q) ? max_pos_q
                                                            : $signed(in_data_i.target);
  assign tgt_ext   = EXT_BITS'(tgt_clamp);
  assign tgt_w     = $signed(tgt_ext[POSITION_BITS-1:0]);
  assign move_dir  = (tgt_w >= pos_q);
  assign tgt_x     = DIST_BITS'(tgt_w);
  assign pos_x     = DIST_BITS'(pos_q);
  assign dist_s    = move_dir ? (tgt_x - pos_x) : (pos_x - tgt_x);
  assign dist_w    = SAT_BITS'($unsigned(dist_s));
  assign units     = (dist_w > SAT_BITS'(UNITS_MAX)) ? UNITS_MAX : dist_w[16:0];
  assign move_null = (units == '0) || (ppu_q == '0);

  // Tick timing
  logic [19:0] phase_inc;
  logic        phase_end, wait_end;
  assign phase_inc = phase_q + 20'd1;
  assign phase_end = (phase_inc >= {4'd0, hp_q});
  assign wait_end  = (phase_inc >= debounce_q);

  // End of a pulse while moving: ramp, unit count
  logic [16:0] hp_sum;
  logic [15:0] hp_ramp;
  logic        ramp_on;
  logic [7:0]  piu_inc;
  logic        unit_end;
  logic [16:0] rem_next;
  logic        move_fin;
  assign ramp_on  = (rem_q < ramp_dist_q) && (hp_q < slow_hp_q);
  assign hp_sum   = {1'b0, hp_q} + {9'd0, ramp_step_q};
  assign hp_ramp  = hp_sum[16] ? PERIOD_MAX : hp_sum[15:0];
  assign piu_inc  = piu_q + 8'd1;
  assign unit_end = (piu_inc >= ppu_q);
  assign rem_next = unit_end ? (rem_q - 17'd1) : rem_q;
  assign move_fin = (rem_next == '0);

  // Pulse low phase has just ended (only used in the move and home modes, not during the debounce wait)
  logic low_end;
  assign low_end = is_tick && phase_end && !high_q;

  // ---------------------------------------------------------------------------
  // Next mode
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d = mode_q;
    if (in_fire) begin
      case (mode_q)
        MODE_IDLE: begin
          if (is_move && !move_null) begin
            mode_d = MODE_MOVE;
          end else if (is_home) begin
            mode_d = MODE_HOME;
          end
        end
        MODE_MOVE: begin
          if (low_end && move_fin) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_HOME: begin
          if (low_end && pressed) begin
            mode_d = (debounce_q == '0) ? MODE_IDLE : MODE_WAIT;
          end
        end
        MODE_WAIT: begin
          if (is_tick && wait_end) begin
            mode_d = pressed ? MODE_IDLE : MODE_HOME;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_d   = pos_q;
    tgt_d   = tgt_q;
    rem_d   = rem_q;
    piu_d   = piu_q;
    hp_d    = hp_q;
    phase_d = phase_q;
    high_d  = high_q;
    dir_d   = dir_q;
    done_d  = 1'b0;
    rej_d   = 1'b0;

    if (is_cmd) begin
      if (busy) begin
        rej_d = 1'b1;
      end else begin
        hp_d = start_hp_q;
        if (is_move) begin
          tgt_d = tgt_w;
          dir_d = move_dir;
          piu_d = '0;
          if (move_null) begin
            // zero-length move, or zero pulses per unit, finishes on the command beat
            pos_d  = tgt_w;
            rem_d  = '0;
            high_d = 1'b0;
            done_d = 1'b1;
          end else begin
            rem_d   = units;
            high_d  = 1'b1;
            phase_d = '0;
          end
        end else begin
          dir_d   = 1'b0;
          high_d  = 1'b1;
          phase_d = '0;
        end
      end
    end else if (is_tick && busy) begin
      phase_d = phase_inc;
      if (mode_q == MODE_WAIT) begin
        if (wait_end) begin
          if (pressed) begin
            pos_d   = '0;
            phase_d = '0;
            done_d  = 1'b1;
          end else begin
            high_d  = 1'b1;
            phase_d = '0;
          end
        end
      end else if (phase_end) begin
        phase_d = '0;
        if (high_q) begin
          high_d = 1'b0;
        end else if (mode_q == MODE_HOME) begin
          if (pressed) begin
            if (debounce_q == '0) begin
              pos_d  = '0;
              done_d = 1'b1;
            end
          end else begin
            high_d = 1'b1;
          end
        end else begin
          if (ramp_on) begin
            hp_d = hp_ramp;
          end
          piu_d = unit_end ? 8'd0 : piu_inc;
          rem_d = rem_next;
          if (move_fin) begin
            pos_d  = tgt_q;
            done_d = 1'b1;
          end else begin
            high_d = 1'b1;
          end
        end
      end
    end
  end

  logic signed [EXT_BITS-1:0] pos_ext;
  assign pos_ext = EXT_BITS'(pos_d);

  always_comb begin
    res_d.step_level = high_d;
    res_d.direction  = dir_d;
    res_d.busy_res   = (mode_d != MODE_IDLE);
    res_d.done_res   = done_d;
    res_d.rejected   = rej_d;
    res_d.position   = $signed(pos_ext[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      tgt_q   <= '0;
      rem_q   <= '0;
      piu_q   <= '0;
      hp_q    <= RST_START_HALF_PERIOD;
      phase_q <= '0;
      high_q  <= 1'b0;
      dir_q   <= 1'b0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      rem_q   <= rem_d;
      piu_q   <= piu_d;
      hp_q    <= hp_d;
      phase_q <= phase_d;
      high_q  <= high_d;
      dir_q   <= dir_d;
    end
  end

  // Result register: loaded on every accepted beat, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fire_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_reject_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && rej_d) |=> ($stable(pos_q) && $stable(mode_q) && $stable(rem_q)))
    else $error("rejected command changed axis state");

  a_step_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.step_level) |-> out_q.busy_res)
    else $error("step pin high while idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> (!out_q.busy_res && !out_q.step_level))
    else $error("done reported while still busy");

endmodule
